// File: src/fixed_point_alu_unit_assert.svh
// ----------------------------------------------------------------------------
// Fixed point ALU assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_UNIT_ASSERT_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed point ALU package
// Widths, operation codes and the records passed along the divider chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int DIV_W     = DATA_W + FRAC_BITS;  // quotient bits, one cell each
  localparam int PROD_W    = 2 * DATA_W;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
  } op_t;

  typedef logic signed [DATA_W-1:0] data_t;

  // result record of everything but the quotient
  typedef struct packed {
    logic  is_div;
    logic  div_neg;
    logic  dz;
    data_t res;
    logic  cmp;
    logic  ovf;
  } side_t;

  // restoring division state: partial remainder, shifting dividend/quotient
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DIV_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } div_t;

endpackage

// File: src/fpa_if.sv
// ----------------------------------------------------------------------------
// Fixed point ALU channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface fpa_in_if import fpa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  data_t       operand_a;
  data_t       operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t result_value;
  logic  compare_true;
  logic  overflow;
  logic  divide_by_zero;

  modport source (output valid, result_value, compare_true, overflow, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_value, compare_true, overflow, divide_by_zero,
                  output ready);
endinterface

// File: src/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed point ALU front end
// Two stages: multiply and divider setup, then all non-divide results.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  op_t   in_op,
  input  data_t in_a,
  input  data_t in_b,
  output logic  out_vld,
  output side_t out_side,
  output div_t  out_div
);

  logic                      s1_vld_r;
  op_t                       s1_op_r;
  data_t                     s1_a_r, s1_b_r;
  logic signed [PROD_W-1:0]  s1_prod_r, s1_prod_nxt;
  logic [DIV_W-1:0]          s1_num_r, s1_num_nxt;
  logic [DATA_W-1:0]         s1_den_r, s1_den_nxt;
  logic signed [PROD_W-1:0]  a_ext, b_ext;
  logic [DATA_W-1:0]         abs_a;

  logic                      s2_vld_r;
  side_t                     s2_side_r, s2_side_nxt;
  div_t                      s2_div_r, s2_div_nxt;

  logic signed [DATA_W:0]    a_x, b_x, sum, dif, incv, decv;
  logic signed [PROD_W-1:0]  p_sh;
  logic [PROD_W-DATA_W:0]    p_top;
  logic [FRAC_BITS:0]        a_top;

  always_comb begin
    a_ext       = PROD_W'(in_a);
    b_ext       = PROD_W'(in_b);
    s1_prod_nxt = a_ext * b_ext;
    abs_a       = in_a[DATA_W-1] ? (~in_a + 1'b1) : in_a;
    s1_num_nxt  = {abs_a, {FRAC_BITS{1'b0}}};
    s1_den_nxt  = in_b[DATA_W-1] ? (~in_b + 1'b1) : in_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= in_op;
      s1_a_r    <= in_a;
      s1_b_r    <= in_b;
      s1_prod_r <= s1_prod_nxt;
      s1_num_r  <= s1_num_nxt;
      s1_den_r  <= s1_den_nxt;
      s2_side_r <= s2_side_nxt;
      s2_div_r  <= s2_div_nxt;
    end
  end

  always_comb begin
    a_x   = (DATA_W+1)'(s1_a_r);
    b_x   = (DATA_W+1)'(s1_b_r);
    sum   = a_x + b_x;
    dif   = a_x - b_x;
    incv  = a_x + (DATA_W+1)'(1);
    decv  = a_x - (DATA_W+1)'(1);
    p_sh  = s1_prod_r >>> FRAC_BITS;
    p_top = p_sh[PROD_W-1:DATA_W-1];
    a_top = s1_a_r[DATA_W-1 -: FRAC_BITS+1];

    s2_side_nxt         = '0;
    s2_side_nxt.div_neg = s1_a_r[DATA_W-1] ^ s1_b_r[DATA_W-1];
    s2_div_nxt.rem      = '0;
    s2_div_nxt.num      = s1_num_r;
    s2_div_nxt.den      = s1_den_r;

    case (s1_op_r)
      OP_ADD: begin
        s2_side_nxt.res = sum[DATA_W-1:0];
        s2_side_nxt.ovf = sum[DATA_W] ^ sum[DATA_W-1];
      end
      OP_SUB: begin
        s2_side_nxt.res = dif[DATA_W-1:0];
        s2_side_nxt.ovf = dif[DATA_W] ^ dif[DATA_W-1];
      end
      OP_MUL: begin
        s2_side_nxt.res = p_sh[DATA_W-1:0];
        s2_side_nxt.ovf = !((&p_top) || !(|p_top));
      end
      OP_DIV: begin
        s2_side_nxt.is_div = 1'b1;
        s2_side_nxt.dz     = (s1_b_r == '0);
      end
      OP_GT:  s2_side_nxt.cmp = (s1_a_r >  s1_b_r);
      OP_LT:  s2_side_nxt.cmp = (s1_a_r <  s1_b_r);
      OP_GE:  s2_side_nxt.cmp = (s1_a_r >= s1_b_r);
      OP_LE:  s2_side_nxt.cmp = (s1_a_r <= s1_b_r);
      OP_EQ:  s2_side_nxt.cmp = (s1_a_r == s1_b_r);
      OP_NE:  s2_side_nxt.cmp = (s1_a_r != s1_b_r);
      OP_MIN: s2_side_nxt.res = (s1_a_r > s1_b_r) ? s1_b_r : s1_a_r;
      OP_MAX: s2_side_nxt.res = (s1_a_r > s1_b_r) ? s1_a_r : s1_b_r;
      OP_INC: begin
        s2_side_nxt.res = incv[DATA_W-1:0];
        s2_side_nxt.ovf = incv[DATA_W] ^ incv[DATA_W-1];
      end
      OP_DEC: begin
        s2_side_nxt.res = decv[DATA_W-1:0];
        s2_side_nxt.ovf = decv[DATA_W] ^ decv[DATA_W-1];
      end
      OP_FROM_INT: begin
        s2_side_nxt.res = s1_a_r <<< FRAC_BITS;
        s2_side_nxt.ovf = !((&a_top) || !(|a_top));
      end
      OP_TO_INT: s2_side_nxt.res = s1_a_r >>> FRAC_BITS;
      default:   s2_side_nxt.res = '0;
    endcase
  end

  assign out_vld  = s2_vld_r;
  assign out_side = s2_side_r;
  assign out_div  = s2_div_r;

endmodule

// File: src/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// Fixed point ALU divider cell
// One restoring-division step per cell; hands the item on each cycle that adv is set.
// ----------------------------------------------------------------------------
module fpa_div_cell import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  side_t in_side,
  input  div_t  in_div,
  output logic  out_vld,
  output side_t out_side,
  output div_t  out_div
);

  logic         vld_r;
  side_t        side_r;
  div_t         div_r, div_nxt;
  logic [DATA_W:0] trial, diff;
  logic         ge;

  // shift in the next dividend bit, subtract the divisor if it fits
  always_comb begin
    trial       = {in_div.rem, in_div.num[DIV_W-1]};
    diff        = trial - {1'b0, in_div.den};
    ge          = (trial >= {1'b0, in_div.den});
    div_nxt.den = in_div.den;
    div_nxt.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    div_nxt.num = {in_div.num[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= in_side;
      div_r  <= div_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_div  = div_r;

endmodule

// File: src/fpa_back.sv
// ----------------------------------------------------------------------------
// Fixed point ALU back end
// Sign and range of the quotient, result select, output register.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  side_t in_side,
  input  div_t  in_div,
  output logic  out_vld,
  output side_t out_side
);

  localparam logic [DIV_W-1:0] LIM = DIV_W'(1) << (DATA_W-1);

  logic             vld_r;
  side_t            side_r, side_nxt;
  logic [DIV_W-1:0] quo, quo_s;
  logic             fits;

  always_comb begin
    quo      = in_div.num;
    quo_s    = in_side.div_neg ? (~quo + 1'b1) : quo;
    fits     = in_side.div_neg ? (quo <= LIM) : (quo < LIM);
    side_nxt = in_side;
    if (in_side.is_div) begin
      if (in_side.dz) begin
        side_nxt.res = '0;
        side_nxt.ovf = 1'b0;
      end else begin
        side_nxt.res = quo_s[DATA_W-1:0];
        side_nxt.ovf = !fits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;

endmodule

// File: src/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// Fixed point ALU unit
// Signed Q24.8 ALU: arithmetic, comparisons, min/max and conversions.
// ----------------------------------------------------------------------------
// One item is taken per cycle while the row advances, and every item yields
// one result after two front stages (a registered 32x32 multiply, then the
// non-divide results), a row of 40 divider cells that each resolve one
// quotient bit of (a << 8) / b, and one output register. All operations ride
// the same row so results leave in order. When the output is not taken the
// whole row holds; in_ready drops only in reset or while a result waits.
module fixed_point_alu_unit import fpa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  fpa_in_if.sink          in_if,
  fpa_out_if.source       out_if
);

  logic  adv;
  logic  back_vld;
  side_t back_side;

  logic  cell_vld  [DIV_W+1];
  side_t cell_side [DIV_W+1];
  div_t  cell_div  [DIV_W+1];

  // advance the whole row when the output register is empty or being taken
  assign adv         = !back_vld || out_if.ready;
  assign in_if.ready = rst_n && adv;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_if.valid && in_if.ready),
    .in_op    (op_t'(in_if.operation)),
    .in_a     (in_if.operand_a),
    .in_b     (in_if.operand_b),
    .out_vld  (cell_vld[0]),
    .out_side (cell_side[0]),
    .out_div  (cell_div[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (cell_vld[i]),
      .in_side  (cell_side[i]),
      .in_div   (cell_div[i]),
      .out_vld  (cell_vld[i+1]),
      .out_side (cell_side[i+1]),
      .out_div  (cell_div[i+1])
    );
  end

  fpa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (cell_vld[DIV_W]),
    .in_side  (cell_side[DIV_W]),
    .in_div   (cell_div[DIV_W]),
    .out_vld  (back_vld),
    .out_side (back_side)
  );

  assign out_if.valid          = back_vld;
  assign out_if.result_value   = back_side.res;
  assign out_if.compare_true   = back_side.cmp;
  assign out_if.overflow       = back_side.ovf;
  assign out_if.divide_by_zero = back_side.dz;

endmodule

// File: src/fpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed point ALU checker
// Port-level properties of the ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_unit_assert.svh"

module fpa_checker import fpa_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input data_t result_value,
  input logic  compare_true,
  input logic  overflow,
  input logic  divide_by_zero
);

  `FPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value), "result changed while stalled")
  `FPA_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with empty output")
  `FPA_ASSERT_NOW(a_cmp_clean, out_valid && compare_true, result_value == '0 && !overflow && !divide_by_zero, "comparison result not clean")
  `FPA_ASSERT_NOW(a_dz_clean, out_valid && divide_by_zero, result_value == '0 && !overflow && !compare_true, "divide by zero result not clean")

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .result_value   (out_if.result_value),
  .compare_true   (out_if.compare_true),
  .overflow       (out_if.overflow),
  .divide_by_zero (out_if.divide_by_zero)
);
